// ===== sv/atcm_pkg.sv =====
`default_nettype none
package atcm_pkg;

  localparam int DATA_W      = 32;
  localparam int IDX_W       = 11;
  localparam int CNT_W       = 11;
  localparam int MODE_W      = 2;
  localparam int PADDR_W     = 4;
  localparam int S_TDATA_W   = 112;
  localparam int S_TUSER_W   = 2;
  localparam int M_TDATA_W   = 64;
  localparam int M_TUSER_W   = 1;

  typedef enum logic [1:0] {
    OP_LOAD_X = 2'd0,
    OP_LOAD_Y = 2'd1,
    OP_FWD    = 2'd2,
    OP_INV    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_XCOUNT = 2'd1,
    REG_YCOUNT = 2'd2,
    REG_NONE   = 2'd3
  } reg_e;

  typedef struct packed {
    logic start;
    logic inv;
    logic en;
    logic ack;
  } lane_ctl_t;

  typedef struct packed {
    logic idle;
    logic done;
    logic status;
  } lane_sts_t;

endpackage
`default_nettype wire

// ===== sv/axis_table_coordinate_mapper_unit.sv =====
// Table-based coordinate mapper, two axes (x, y), signed fixed point.
// Input stream s_axis: tuser carries the op (load x, load y, forward, inverse),
// tdata carries entry index/value for loads and coord_x/coord_y for maps.
// Load transfers write one table entry (1-based index) and give no output.
// Each map transfer gives one output transfer on m_axis: result_x, result_y
// in tdata and the zero-width-interval flag in tuser.
// Config through the APB port: mapping mode at 0x0, x count at 0x4,
// y count at 0x8; write only while idle.
// Both axes run in their own lane in parallel, each with its own table RAM;
// the slower lane sets the item time. Forward maps use a serial multiply
// over 33 offset bits; inverse maps take s search steps (about log2(count-1)),
// one RAM read per step, and a one-bit-per-cycle divide over 32+FRAC_BITS
// bits; a zero-width interval skips the divide. An axis whose mode bit is
// clear passes its coordinate through. A load is written to the table RAM
// when accepted. s_axis_tready rises in the cycle the result is registered.
// One map item is in flight at a time; the result sits in an output register
// so the next item is taken while it waits for m_axis_tready.
// Reset clears control state and the mode; x and y count reset to 1024.
// Table contents are undefined until loaded.
`default_nettype none
module axis_table_coordinate_mapper_unit #(
  parameter int TABLE_DEPTH = 1024,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // entry_index[10:0], entry_value[42:11], coord_x[74:43], coord_y[106:75]
  input  wire logic [atcm_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // op[1:0]
  input  wire logic [atcm_pkg::S_TUSER_W-1:0]     s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // result_x[31:0], result_y[63:32]
  output logic [atcm_pkg::M_TDATA_W-1:0]          m_axis_tdata,
  // status[0]
  output logic [atcm_pkg::M_TUSER_W-1:0]          m_axis_tuser,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [atcm_pkg::PADDR_W-1:0]       paddr,
  input  wire logic [31:0]                        pwdata,
  output logic [31:0]                             prdata,
  output logic                                    pready
);
  import atcm_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = $clog2(TABLE_DEPTH);

  logic [MODE_W-1:0] mode_q;
  logic [CNT_W-1:0]  xcount_q, ycount_q;
  logic              busy_q, busy_d;
  logic              ovalid_q, ovalid_d;
  logic [31:0]       rx_q, ry_q;
  logic              rs_q;

  op_e               op;
  reg_e              reg_sel;
  logic [IDX_W-1:0]  entry_index;
  logic [31:0]       entry_value;
  logic signed [31:0] coord_x, coord_y;
  logic              s_acc, cfg_wr, idx_ok, take;
  logic [AW-1:0]     wr_addr;
  logic [IW-1:0]     nx, ny;
  lane_ctl_t         ctl_x, ctl_y;
  lane_sts_t         sts_x, sts_y;
  logic [31:0]       res_x, res_y;

  assign op          = op_e'(s_axis_tuser[1:0]);
  assign entry_index = s_axis_tdata[10:0];
  assign entry_value = s_axis_tdata[42:11];
  assign coord_x     = s_axis_tdata[74:43];
  assign coord_y     = s_axis_tdata[106:75];

  assign reg_sel = reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    case (reg_sel)
      REG_MODE:   prdata = {{(32-MODE_W){1'b0}}, mode_q};
      REG_XCOUNT: prdata = {{(32-CNT_W){1'b0}}, xcount_q};
      REG_YCOUNT: prdata = {{(32-CNT_W){1'b0}}, ycount_q};
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    if (xcount_q < CNT_W'(2)) begin
      nx = IW'(2);
    end else if ({{(32-CNT_W){1'b0}}, xcount_q} > 32'(TABLE_DEPTH)) begin
      nx = IW'(TABLE_DEPTH);
    end else begin
      nx = IW'(xcount_q);
    end
    if (ycount_q < CNT_W'(2)) begin
      ny = IW'(2);
    end else if ({{(32-CNT_W){1'b0}}, ycount_q} > 32'(TABLE_DEPTH)) begin
      ny = IW'(TABLE_DEPTH);
    end else begin
      ny = IW'(ycount_q);
    end
  end

  assign s_axis_tready = !busy_q;
  assign s_acc   = s_axis_tvalid && s_axis_tready;
  assign idx_ok  = (entry_index != '0)
                && ({{(32-IDX_W){1'b0}}, entry_index} <= 32'(TABLE_DEPTH));
  assign wr_addr = AW'({{(32-IDX_W){1'b0}}, entry_index} - 32'd1);
  assign take    = sts_x.done && sts_y.done && (!ovalid_q || m_axis_tready);

  always_comb begin
    ctl_x.start = s_acc && (op == OP_FWD || op == OP_INV);
    ctl_x.inv   = op == OP_INV;
    ctl_x.en    = mode_q[0];
    ctl_x.ack   = take;
    ctl_y       = ctl_x;
    ctl_y.en    = mode_q[1];
  end

  atcm_lane #(.TABLE_DEPTH(TABLE_DEPTH), .FRAC_BITS(FRAC_BITS)) u_lane_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl_x),
    .sts_o    (sts_x),
    .value_i  (coord_x),
    .count_i  (nx),
    .wr_en_i  (s_acc && op == OP_LOAD_X && idx_ok),
    .wr_addr_i(wr_addr),
    .wr_data_i(entry_value),
    .result_o (res_x)
  );

  atcm_lane #(.TABLE_DEPTH(TABLE_DEPTH), .FRAC_BITS(FRAC_BITS)) u_lane_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl_y),
    .sts_o    (sts_y),
    .value_i  (coord_y),
    .count_i  (ny),
    .wr_en_i  (s_acc && op == OP_LOAD_Y && idx_ok),
    .wr_addr_i(wr_addr),
    .wr_data_i(entry_value),
    .result_o (res_y)
  );

  always_comb begin
    busy_d   = busy_q;
    ovalid_d = ovalid_q;
    if (m_axis_tvalid && m_axis_tready) begin
      ovalid_d = 1'b0;
    end
    if (take) begin
      ovalid_d = 1'b1;
      busy_d   = 1'b0;
    end
    if (ctl_x.start) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      ovalid_q <= 1'b0;
      mode_q   <= '0;
      xcount_q <= CNT_W'(1024);
      ycount_q <= CNT_W'(1024);
    end else begin
      busy_q   <= busy_d;
      ovalid_q <= ovalid_d;
      if (cfg_wr) begin
        case (reg_sel)
          REG_MODE:   mode_q   <= pwdata[MODE_W-1:0];
          REG_XCOUNT: xcount_q <= pwdata[CNT_W-1:0];
          REG_YCOUNT: ycount_q <= pwdata[CNT_W-1:0];
          default:    ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      rx_q <= res_x;
      ry_q <= res_y;
      rs_q <= sts_x.status | sts_y.status;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {ry_q, rx_q};
  assign m_axis_tuser  = rs_q;

  a_idle_lanes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> sts_x.idle && sts_y.idle)
    else $error("lane active while unit idle");

  a_lanes_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> m_axis_tvalid && !busy_q)
    else $error("merged result lost");

endmodule
`default_nettype wire

// ===== sv/atcm_ram.sv =====
`default_nettype none
module atcm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end
endmodule
`default_nettype wire

// ===== sv/atcm_lane.sv =====
`default_nettype none
module atcm_lane #(
  parameter int TABLE_DEPTH = 1024,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire atcm_pkg::lane_ctl_t                   ctl_i,
  output atcm_pkg::lane_sts_t                        sts_o,
  input  wire logic signed [31:0]                    value_i,
  input  wire logic [$clog2(TABLE_DEPTH+1)-1:0]      count_i,
  input  wire logic                                  wr_en_i,
  input  wire logic [$clog2(TABLE_DEPTH)-1:0]        wr_addr_i,
  input  wire logic [31:0]                           wr_data_i,
  output logic [31:0]                                result_o
);
  import atcm_pkg::*;

  localparam int IW  = $clog2(TABLE_DEPTH + 1);
  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int F   = FRAC_BITS;
  localparam int DXW = (IW + F + 2 > 33) ? IW + F + 2 : 33;
  localparam int PW  = 32 + DXW;
  localparam int NW  = 32 + F;
  localparam int SW  = (PW + 2 - F > NW + 2) ? PW + 2 - F : NW + 2;
  localparam int CW  = $clog2(((NW > DXW) ? NW : DXW) + 1);

  typedef enum logic [17:0] {
    S_IDLE = 18'h00001,
    S_FRA  = 18'h00002,
    S_FRB  = 18'h00004,
    S_FSUB = 18'h00008,
    S_MUL  = 18'h00010,
    S_FNEG = 18'h00020,
    S_IR1  = 18'h00040,
    S_IRN  = 18'h00080,
    S_IDIR = 18'h00100,
    S_IM   = 18'h00200,
    S_ICMP = 18'h00400,
    S_IPA  = 18'h00800,
    S_IPB  = 18'h01000,
    S_ISUB = 18'h02000,
    S_DIV  = 18'h04000,
    S_INEG = 18'h08000,
    S_ADD  = 18'h10000,
    S_DONE = 18'h20000
  } state_e;

  state_e state_q, state_d;

  logic signed [31:0]  pos_q, pos_d;
  logic [IW-1:0]       n_q, n_d, lo_q, lo_d, hi_q, hi_d, m_q, m_d;
  logic                asc_q, asc_d, neg_q, neg_d, status_q, status_d;
  logic [31:0]         ta_q, ta_d, mula_q, mula_d, dmag_q, dmag_d, rem_q, rem_d;
  logic [31:0]         res_q, res_d;
  logic signed [DXW-1:0] dx_q, dx_d;
  logic [DXW-1:0]      mulb_q, mulb_d;
  logic [PW-1:0]       acc_q, acc_d;
  logic [NW-1:0]       dvd_q, dvd_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic signed [SW-1:0] add_a_q, add_a_d, add_b_q, add_b_d;

  logic [AW-1:0]       rd_addr;
  logic [31:0]         rd_data;
  logic signed [31:0]  ipos;
  logic [IW-1:0]       nm1, fidx, m_nx;
  logic [IW:0]         sumlh;
  logic signed [32:0]  diff, num;
  logic [31:0]         diff_mag, num_mag;
  logic [DXW-1:0]      dx_mag;
  logic [32:0]         trial;
  logic                trial_ge, go_hi;
  logic [PW:0]         prod;
  logic [NW:0]         qs;
  logic signed [SW-1:0] sum;
  logic [SW-32:0]      sum_hi;

  atcm_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en_i),
    .wr_addr_i(wr_addr_i),
    .wr_data_i(wr_data_i),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  always_comb begin
    ipos  = value_i >>> F;
    nm1   = count_i - IW'(1);
    if (ipos < 32'sd1) begin
      fidx = IW'(1);
    end else if (ipos > $signed({{(32-IW){1'b0}}, nm1})) begin
      fidx = nm1;
    end else begin
      fidx = ipos[IW-1:0];
    end
    sumlh    = {1'b0, lo_q} + {1'b0, hi_q} + {{IW{1'b0}}, ~asc_q};
    m_nx     = sumlh[IW:1];
    diff     = {rd_data[31], rd_data} - {ta_q[31], ta_q};
    num      = {pos_q[31], pos_q} - {ta_q[31], ta_q};
    diff_mag = diff[32] ? 32'(-diff) : diff[31:0];
    num_mag  = num[32] ? 32'(-num) : num[31:0];
    dx_mag   = dx_q[DXW-1] ? DXW'(-dx_q) : DXW'(dx_q);
    trial    = {rem_q, dvd_q[NW-1]};
    trial_ge = trial >= {1'b0, dmag_q};
    go_hi    = asc_q ? ($signed(pos_q) <= $signed(rd_data))
                     : ($signed(pos_q) >= $signed(rd_data));
    prod     = neg_q ? (PW+1)'(-{1'b0, acc_q}) : {1'b0, acc_q};
    qs       = neg_q ? (NW+1)'(-{1'b0, dvd_q}) : {1'b0, dvd_q};
    sum      = add_a_q + add_b_q;
    sum_hi   = sum[SW-1:31];
  end

  always_comb begin
    case (state_q)
      S_FRA:   rd_addr = AW'(m_q - IW'(1));
      S_FRB:   rd_addr = AW'(m_q);
      S_IR1:   rd_addr = '0;
      S_IRN:   rd_addr = AW'(n_q - IW'(1));
      S_IM:    rd_addr = AW'(m_nx - IW'(1));
      S_IPA:   rd_addr = AW'(m_q - IW'(1));
      S_IPB:   rd_addr = asc_q ? AW'(m_q) : AW'(m_q - IW'(2));
      default: rd_addr = '0;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    pos_d    = pos_q;
    n_d      = n_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    m_d      = m_q;
    asc_d    = asc_q;
    neg_d    = neg_q;
    status_d = status_q;
    ta_d     = ta_q;
    mula_d   = mula_q;
    mulb_d   = mulb_q;
    dmag_d   = dmag_q;
    rem_d    = rem_q;
    res_d    = res_q;
    dx_d     = dx_q;
    acc_d    = acc_q;
    dvd_d    = dvd_q;
    cnt_d    = cnt_q;
    add_a_d  = add_a_q;
    add_b_d  = add_b_q;
    case (state_q)
      S_IDLE: begin
        if (ctl_i.start) begin
          pos_d    = value_i;
          n_d      = count_i;
          status_d = 1'b0;
          m_d      = fidx;
          if (!ctl_i.en) begin
            res_d   = value_i;
            state_d = S_DONE;
          end else if (ctl_i.inv) begin
            state_d = S_IR1;
          end else begin
            state_d = S_FRA;
          end
        end
      end
      S_FRA: begin
        dx_d    = $signed({{(DXW-32){pos_q[31]}}, pos_q})
                - $signed({{(DXW-IW-F){1'b0}}, m_q, {F{1'b0}}});
        state_d = S_FRB;
      end
      S_FRB: begin
        ta_d    = rd_data;
        state_d = S_FSUB;
      end
      S_FSUB: begin
        mula_d  = diff_mag;
        mulb_d  = dx_mag;
        neg_d   = diff[32] ^ dx_q[DXW-1];
        acc_d   = '0;
        cnt_d   = CW'(DXW);
        state_d = S_MUL;
      end
      S_MUL: begin
        acc_d  = {acc_q[PW-2:0], 1'b0} + (mulb_q[DXW-1] ? PW'(mula_q) : PW'(0));
        mulb_d = {mulb_q[DXW-2:0], 1'b0};
        cnt_d  = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          state_d = S_FNEG;
        end
      end
      S_FNEG: begin
        add_a_d = SW'($signed(ta_q));
        add_b_d = SW'($signed(prod[PW:F]));
        state_d = S_ADD;
      end
      S_IR1: state_d = S_IRN;
      S_IRN: begin
        ta_d    = rd_data;
        state_d = S_IDIR;
      end
      S_IDIR: begin
        asc_d   = $signed(ta_q) < $signed(rd_data);
        lo_d    = IW'(1);
        hi_d    = n_q;
        state_d = S_IM;
      end
      S_IM: begin
        m_d = m_nx;
        if (asc_q ? (m_nx == lo_q) : (m_nx == hi_q)) begin
          state_d = S_IPA;
        end else begin
          state_d = S_ICMP;
        end
      end
      S_ICMP: begin
        if (go_hi) begin
          hi_d = m_q;
        end else begin
          lo_d = m_q;
        end
        state_d = S_IM;
      end
      S_IPA: state_d = S_IPB;
      S_IPB: begin
        ta_d    = rd_data;
        state_d = S_ISUB;
      end
      S_ISUB: begin
        add_a_d = $signed({{(SW-IW-F){1'b0}}, m_q, {F{1'b0}}});
        if (diff == 33'sd0) begin
          status_d = 1'b1;
          add_b_d  = '0;
          state_d  = S_ADD;
        end else begin
          dmag_d  = diff_mag;
          dvd_d   = {num_mag, {F{1'b0}}};
          rem_d   = '0;
          neg_d   = num[32] ^ diff[32] ^ ~asc_q;
          cnt_d   = CW'(NW);
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        rem_d = trial_ge ? 32'(trial - {1'b0, dmag_q}) : trial[31:0];
        dvd_d = {dvd_q[NW-2:0], trial_ge};
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          state_d = S_INEG;
        end
      end
      S_INEG: begin
        add_b_d = SW'($signed(qs));
        state_d = S_ADD;
      end
      S_ADD: begin
        if ((&sum_hi) || !(|sum_hi)) begin
          res_d = sum[31:0];
        end else begin
          res_d = sum[SW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (ctl_i.ack) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    n_q      <= n_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    m_q      <= m_d;
    asc_q    <= asc_d;
    neg_q    <= neg_d;
    status_q <= status_d;
    ta_q     <= ta_d;
    mula_q   <= mula_d;
    mulb_q   <= mulb_d;
    dmag_q   <= dmag_d;
    rem_q    <= rem_d;
    res_q    <= res_d;
    dx_q     <= dx_d;
    acc_q    <= acc_d;
    dvd_q    <= dvd_d;
    cnt_q    <= cnt_d;
    add_a_q  <= add_a_d;
    add_b_q  <= add_b_d;
  end

  assign sts_o.idle   = state_q == S_IDLE;
  assign sts_o.done   = state_q == S_DONE;
  assign sts_o.status = status_q;
  assign result_o     = res_q;

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> dmag_q != 32'd0)
    else $error("divide with zero interval width");

  a_bracket_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IM |-> lo_q < hi_q)
    else $error("search bracket collapsed");

  a_bracket_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IPA |-> (m_q >= IW'(1)) && (m_q <= n_q))
    else $error("bracket index out of table");

endmodule
`default_nettype wire
